[sv/ccse_pkg.sv]
// Shared types and constants of the CRC codeword stream encoder.
package ccse_pkg;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int NIB_W  = 4;
	localparam int PAD_W  = 3;
	// Header byte plus up to seven pad bits
	localparam int HDR_W  = BYTE_W + 7;

	// Configuration register widths
	localparam int GEN_BITS_W = 16;
	localparam int GEN_LEN_W  = 5;
	localparam int MSG_W      = 16;

	// APB data and address widths
	localparam int APB_DW = 32;
	localparam int APB_AW = 4;

	// Reset values of the configuration registers
	localparam logic [GEN_BITS_W-1:0] GEN_BITS_RST = 16'd13;
	localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = 5'd4;
	localparam logic                  WORD_MODE_RST = 1'b1;
	localparam logic [MSG_W-1:0]      MSG_RST      = 16'd1;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_GEN_BITS  = 2'd0,
		REG_GEN_LEN   = 2'd1,
		REG_WORD_MODE = 2'd2,
		REG_MSG_BYTES = 2'd3
	} reg_idx_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [GEN_BITS_W-1:0] gen_bits;
		logic [GEN_LEN_W-1:0]  gen_len;
		logic                  word_mode;
		logic [MSG_W-1:0]      message_bytes;
	} cfg_t;

endpackage

[sv/ccse_front.sv]
// Front end: takes input beats, classifies them and builds left-aligned bit chunks.
module ccse_front #(
	parameter int MAX_GEN_LEN = 16,
	parameter int LENGTH_BITS = 16,
	localparam int R_MAX = MAX_GEN_LEN - 1,
	localparam int RW    = $clog2(MAX_GEN_LEN),
	localparam int CW_W  = 2 * ccse_pkg::NIB_W + 2 * R_MAX,
	localparam int ENT_W = ccse_pkg::HDR_W + CW_W,
	localparam int LW    = $clog2(ENT_W + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ccse_pkg::cfg_t              cfg,
	input  logic                        push,
	output logic                        full,
	input  logic [ccse_pkg::BYTE_W-1:0] data_byte,
	output logic                        q_push,
	input  logic                        q_full,
	output logic [ENT_W-1:0]            q_bits,
	output logic [LW-1:0]               q_len,
	output logic                        q_last,
	output logic                        q_hdr
);

	localparam int CWH_W = ccse_pkg::NIB_W + R_MAX;

	logic [LENGTH_BITS-1:0] cnt_q;
	logic [LENGTH_BITS-1:0] msg;
	logic [LENGTH_BITS-1:0] cnt_nxt;
	logic [RW-1:0]          r_eff;
	logic [7:0]             r_ext;
	logic [ccse_pkg::PAD_W-1:0] pb3;
	logic [ccse_pkg::PAD_W-1:0] rem3;
	logic [ccse_pkg::PAD_W-1:0] pad3;
	logic                   acc_in;
	logic                   hdr_in;
	logic                   last_in;
	logic                   ld2;

	// stage 1
	logic                        v_s1;
	logic [ccse_pkg::BYTE_W-1:0] data_s1;
	logic                        hdr_s1;
	logic [ccse_pkg::PAD_W-1:0]  pad_s1;
	logic                        last_s1;
	logic [RW-1:0]               r_s1;
	logic                        mode_s1;

	// stage 2
	logic                        v_s2;
	logic [CW_W-1:0]             cw_s2;
	logic [LW-1:0]               cwlen_s2;
	logic                        hdr_s2;
	logic [ccse_pkg::PAD_W-1:0]  pad_s2;
	logic                        last_s2;

	logic [R_MAX-1:0] gm;
	logic [R_MAX-1:0] gmask;
	logic [R_MAX-1:0] gl;
	logic [R_MAX-1:0] rem_w;
	logic [R_MAX-1:0] rem_a;
	logic [R_MAX-1:0] rem_b;
	logic             fb_w;
	logic             fb_a;
	logic             fb_b;
	logic [CWH_W-1:0] cwa;
	logic [CWH_W-1:0] cwb;
	logic [CW_W-1:0]  cw;
	logic [LW-1:0]    cwlen;
	logic [LW-1:0]    hlen;
	logic [ENT_W-1:0] hvec;

	// effective remainder length, generator length clamped to 1..MAX_GEN_LEN
	always_comb begin
		if (cfg.gen_len == '0) begin
			r_eff = '0;
		end else if (int'(cfg.gen_len) > MAX_GEN_LEN) begin
			r_eff = RW'(R_MAX);
		end else begin
			r_eff = RW'(cfg.gen_len - 5'd1);
		end
	end

	// pad count: only the low three bits of length and bits per byte matter
	assign msg   = LENGTH_BITS'(cfg.message_bytes);
	assign r_ext = 8'(r_eff);
	assign pb3   = cfg.word_mode ? r_ext[2:0] : {r_ext[1:0], 1'b0};
	assign rem3  = 3'(msg[2:0] * pb3);
	assign pad3  = 3'd0 - rem3;

	// message position
	assign acc_in  = push && !full;
	assign hdr_in  = (cnt_q == '0);
	assign cnt_nxt = cnt_q + LENGTH_BITS'(1);
	assign last_in = (cnt_nxt == msg);

	// stall chain
	assign ld2    = v_s1 && (!v_s2 || !q_full);
	assign full   = v_s1 && v_s2 && q_full;
	assign q_push = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc_in) begin
			cnt_q <= last_in ? '0 : cnt_nxt;
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc_in) begin
			v_s1 <= 1'b1;
		end else if (ld2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			data_s1 <= data_byte;
			hdr_s1  <= hdr_in;
			pad_s1  <= hdr_in ? pad3 : '0;
			last_s1 <= last_in;
			r_s1    <= r_eff;
			mode_s1 <= cfg.word_mode;
		end
	end

	// generator low r bits, left aligned in the remainder register
	assign gm    = R_MAX'(cfg.gen_bits);
	assign gmask = ~({R_MAX{1'b1}} << r_s1);
	assign gl    = (gm & gmask) << (R_MAX - int'(r_s1));

	// bit-serial division, remainder kept left aligned
	always_comb begin
		rem_w = '0;
		rem_a = '0;
		rem_b = '0;
		fb_w  = 1'b0;
		fb_a  = 1'b0;
		fb_b  = 1'b0;
		for (int i = ccse_pkg::BYTE_W - 1; i >= 0; i--) begin
			fb_w  = data_s1[i] ^ rem_w[R_MAX-1];
			rem_w = (rem_w << 1) ^ (fb_w ? gl : '0);
		end
		for (int i = ccse_pkg::NIB_W - 1; i >= 0; i--) begin
			fb_a  = data_s1[ccse_pkg::NIB_W + i] ^ rem_a[R_MAX-1];
			rem_a = (rem_a << 1) ^ (fb_a ? gl : '0);
			fb_b  = data_s1[i] ^ rem_b[R_MAX-1];
			rem_b = (rem_b << 1) ^ (fb_b ? gl : '0);
		end
	end

	// codeword bits, left aligned
	assign cwa = {data_s1[ccse_pkg::BYTE_W-1:ccse_pkg::NIB_W], rem_a};
	assign cwb = {data_s1[ccse_pkg::NIB_W-1:0], rem_b};

	always_comb begin
		if (mode_s1) begin
			cw    = {data_s1, rem_w, {R_MAX{1'b0}}};
			cwlen = LW'(ccse_pkg::BYTE_W) + LW'(r_s1);
		end else begin
			cw    = {cwa, {CWH_W{1'b0}}}
				| ({cwb, {CWH_W{1'b0}}} >> (ccse_pkg::NIB_W + int'(r_s1)));
			cwlen = LW'(ccse_pkg::BYTE_W) + LW'(r_s1) + LW'(r_s1);
		end
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld2) begin
			v_s2 <= 1'b1;
		end else if (!q_full) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			cw_s2    <= cw;
			cwlen_s2 <= cwlen;
			hdr_s2   <= hdr_s1;
			pad_s2   <= pad_s1;
			last_s2  <= last_s1;
		end
	end

	// chunk: optional header byte and pad zeros, then codeword bits
	assign hvec = {8'(pad_s2), {(ENT_W - ccse_pkg::BYTE_W){1'b0}}};
	assign hlen = hdr_s2 ? LW'(ccse_pkg::BYTE_W) + LW'(pad_s2) : '0;

	assign q_bits = (hdr_s2 ? hvec : '0) | ({cw_s2, {ccse_pkg::HDR_W{1'b0}}} >> hlen);
	assign q_len  = hlen + cwlen_s2;
	assign q_last = last_s2;
	// header chunk opens a message, packer drops any stale partial byte
	assign q_hdr  = hdr_s2;

endmodule

[sv/ccse_fifo.sv]
// Short register queue between the front end and the packer.
module ccse_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign dout  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_rd) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

[sv/ccse_pack.sv]
// Back end: packs bit chunks MSB first into output bytes and flushes at message end.
module ccse_pack #(
	parameter int ENT_W = 53,
	localparam int LW    = $clog2(ENT_W + 1),
	localparam int ACC_W = ENT_W + ccse_pkg::BYTE_W - 1,
	localparam int CNT_W = $clog2(ACC_W + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  logic [ENT_W-1:0]            q_bits,
	input  logic [LW-1:0]               q_len,
	input  logic                        q_last,
	input  logic                        q_hdr,
	output logic                        empty,
	input  logic                        pop,
	output logic [ccse_pkg::BYTE_W-1:0] out_byte,
	output logic                        last_byte
);

	logic [ACC_W-1:0]            acc_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        lst_q;
	logic                        ov_q;
	logic [ccse_pkg::BYTE_W-1:0] ob_q;
	logic                        ol_q;
	logic                        busy;
	logic                        emit;
	logic                        blast;
	logic [ccse_pkg::PAD_W-1:0]  ld_sh;
	logic [ACC_W-1:0]            ld_vec;

	// a byte is ready, or a partial byte must be flushed at message end
	assign busy  = (cnt_q >= CNT_W'(ccse_pkg::BYTE_W)) || (lst_q && cnt_q != '0);
	assign emit  = busy && (!ov_q || pop);
	assign blast = lst_q && (cnt_q <= CNT_W'(ccse_pkg::BYTE_W));
	assign q_pop = !busy && !q_empty;

	// new chunk goes right after the leftover bits; a header chunk starts clean
	assign ld_sh  = q_hdr ? '0 : cnt_q[2:0];
	assign ld_vec = {q_bits, {(ccse_pkg::BYTE_W - 1){1'b0}}} >> ld_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			lst_q <= 1'b0;
		end else if (emit) begin
			acc_q <= acc_q << ccse_pkg::BYTE_W;
			cnt_q <= (cnt_q > CNT_W'(ccse_pkg::BYTE_W)) ?
				cnt_q - CNT_W'(ccse_pkg::BYTE_W) : '0;
		end else if (q_pop) begin
			acc_q <= (q_hdr ? '0 : acc_q) | ld_vec;
			cnt_q <= (q_hdr ? '0 : cnt_q) + CNT_W'(q_len);
			lst_q <= q_last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q <= acc_q[ACC_W-1 -: ccse_pkg::BYTE_W];
			ol_q <= blast;
		end
	end

	assign empty     = !ov_q;
	assign out_byte  = ob_q;
	assign last_byte = ol_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ACC_W))
		else $error("packer bit count overflow");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit && blast |=> cnt_q == '0)
		else $error("bits left after final byte of message");

	a_clean_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q << cnt_q) == '0)
		else $error("stale bits below valid packer bits");
`endif

endmodule

[sv/crc_codeword_stream_encoder_unit.sv]
// An item's first output byte passes front stages 1 and 2, the queue, the packer accumulator
// and the output register. The packer emits one byte per cycle while its output is free or
// popped, and loads the next item only after all whole bytes are out. Items yield 1 to 6 bytes.
// The front end accepts a beat every cycle while its two stages and the 4-entry queue have room.
// Reset (arst_n low, asynchronous): queues, message counter and leftover bits cleared;
// gen_bits=13, gen_len=4, word_mode=1, message_bytes=1.
module crc_codeword_stream_encoder_unit #(
	parameter int MAX_GEN_LEN = 16,
	parameter int LENGTH_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ccse_pkg::APB_AW-1:0] paddr,
	input  logic [ccse_pkg::APB_DW-1:0] pwdata,
	output logic [ccse_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	// input beats
	input  logic                        push,
	output logic                        full,
	input  logic [ccse_pkg::BYTE_W-1:0] data_byte,
	// output beats
	output logic                        empty,
	input  logic                        pop,
	output logic [ccse_pkg::BYTE_W-1:0] out_byte,
	output logic                        last_byte
);

	localparam int R_MAX  = MAX_GEN_LEN - 1;
	localparam int CW_W   = 2 * ccse_pkg::NIB_W + 2 * R_MAX;
	localparam int ENT_W  = ccse_pkg::HDR_W + CW_W;
	localparam int LW     = $clog2(ENT_W + 1);
	localparam int QW     = ENT_W + LW + 2;
	localparam int QDEPTH = 4;

	ccse_pkg::cfg_t     cfg_q;
	ccse_pkg::reg_idx_t ridx;
	logic               wr_en;

	logic             f_push;
	logic             f_full;
	logic [ENT_W-1:0] f_bits;
	logic [LW-1:0]    f_len;
	logic             f_last;
	logic             f_hdr;
	logic             b_empty;
	logic             b_pop;
	logic [QW-1:0]    b_dout;

	// register file
	assign ridx   = ccse_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gen_bits      <= ccse_pkg::GEN_BITS_RST;
			cfg_q.gen_len       <= ccse_pkg::GEN_LEN_RST;
			cfg_q.word_mode     <= ccse_pkg::WORD_MODE_RST;
			cfg_q.message_bytes <= ccse_pkg::MSG_RST;
		end else if (wr_en) begin
			unique case (ridx)
				ccse_pkg::REG_GEN_BITS: begin
					cfg_q.gen_bits <= pwdata[ccse_pkg::GEN_BITS_W-1:0];
				end
				ccse_pkg::REG_GEN_LEN: begin
					cfg_q.gen_len <= pwdata[ccse_pkg::GEN_LEN_W-1:0];
				end
				ccse_pkg::REG_WORD_MODE: begin
					cfg_q.word_mode <= pwdata[0];
				end
				ccse_pkg::REG_MSG_BYTES: begin
					cfg_q.message_bytes <= pwdata[ccse_pkg::MSG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (ridx)
			ccse_pkg::REG_GEN_BITS:  prdata = ccse_pkg::APB_DW'(cfg_q.gen_bits);
			ccse_pkg::REG_GEN_LEN:   prdata = ccse_pkg::APB_DW'(cfg_q.gen_len);
			ccse_pkg::REG_WORD_MODE: prdata = ccse_pkg::APB_DW'(cfg_q.word_mode);
			ccse_pkg::REG_MSG_BYTES: prdata = ccse_pkg::APB_DW'(cfg_q.message_bytes);
			default:                 prdata = '0;
		endcase
	end

	ccse_front #(
		.MAX_GEN_LEN (MAX_GEN_LEN),
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.q_push    (f_push),
		.q_full    (f_full),
		.q_bits    (f_bits),
		.q_len     (f_len),
		.q_last    (f_last),
		.q_hdr     (f_hdr)
	);

	ccse_fifo #(
		.WIDTH (QW),
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (f_full),
		.din    ({f_hdr, f_last, f_len, f_bits}),
		.pop    (b_pop),
		.empty  (b_empty),
		.dout   (b_dout)
	);

	ccse_pack #(
		.ENT_W (ENT_W)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (b_empty),
		.q_pop     (b_pop),
		.q_bits    (b_dout[ENT_W-1:0]),
		.q_len     (b_dout[ENT_W +: LW]),
		.q_last    (b_dout[ENT_W + LW]),
		.q_hdr     (b_dout[QW-1]),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
